// ----- design/tbvf_pkg.sv -----
// ----------------------------------------------------------------------------
// tbvf_pkg
// Widths and constants of the rotating-frame three-body vector field.
// ----------------------------------------------------------------------------
`default_nettype none

package tbvf_pkg;

  // fixed point format of every state and derivative element
  localparam int unsigned DataW  = 40;
  localparam int unsigned FracW  = 32;
  localparam int unsigned NumElem = 6;
  localparam int unsigned TDataW = NumElem * DataW;
  localparam int unsigned TUserW = 2;

  // mass ratio and gravity coefficients
  localparam int unsigned MuW    = 32;
  localparam int unsigned CoefW  = MuW + 1;
  localparam logic [MuW-1:0] MuReset = 32'd52731336;

  // datapath widths
  localparam int unsigned MagW   = DataW + 1;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned SumW   = SqW + 2;
  localparam int unsigned RootW  = SumW / 2;
  localparam int unsigned QW     = SumW - FracW;
  localparam int unsigned CubeW  = QW + RootW;
  localparam int unsigned ProdW  = CoefW + MagW;
  localparam int unsigned NumW   = ProdW + FracW;
  localparam int unsigned QuoW   = 51;
  localparam int unsigned GravW  = QuoW + 1;
  localparam int unsigned AccW   = GravW + 3;

  // pipeline latencies
  localparam int unsigned MulLat = 2;
  localparam int unsigned DivLat = QuoW + 2;

  // register file
  localparam int unsigned AddrW  = 3;
  localparam int unsigned PDataW = 32;
  localparam logic [AddrW-3:0] RegMassRatio = '0;

endpackage

`default_nettype wire

// ----- design/three_body_vector_field_top.sv -----
// ----------------------------------------------------------------------------
// three_body_vector_field_top
// Derivative of a restricted three-body state in the rotating frame.
// ----------------------------------------------------------------------------
// A state (position and velocity, signed Q8.32) enters on the slave stream;
// its derivative leaves on the master stream with flags in tuser. The mass
// ratio mu sits in the APB register at address 0 and is sampled as each
// transaction is accepted.
// From acceptance to tvalid on the output a transaction passes through 102
// register stages: input stage, split squaring multipliers, distance sum, a
// 42-stage square root, the cube multiplier, six parallel 53-stage dividers
// and the output register.
// One transaction per cycle unless stalled: every stage advances together.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops in the same cycle; nothing is
// lost or repeated. Reset clears all valid bits and loads mu with its
// default value.
// ----------------------------------------------------------------------------
`default_nettype none

module three_body_vector_field_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  wire  [tbvf_pkg::TDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // dpos_x, dpos_y, dpos_z, accel_x, accel_y, accel_z
  output logic [tbvf_pkg::TDataW-1:0]     m_axis_tdata,
  // saturated, singular
  output logic [tbvf_pkg::TUserW-1:0]     m_axis_tuser,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [tbvf_pkg::AddrW-1:0]      paddr,
  input  wire  [tbvf_pkg::PDataW-1:0]     pwdata,
  output logic [tbvf_pkg::PDataW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned DataW  = tbvf_pkg::DataW;
  localparam int unsigned FracW  = tbvf_pkg::FracW;
  localparam int unsigned CoefW  = tbvf_pkg::CoefW;
  localparam int unsigned MagW   = tbvf_pkg::MagW;
  localparam int unsigned SqW    = tbvf_pkg::SqW;
  localparam int unsigned SumW   = tbvf_pkg::SumW;
  localparam int unsigned RootW  = tbvf_pkg::RootW;
  localparam int unsigned QW     = tbvf_pkg::QW;
  localparam int unsigned CubeW  = tbvf_pkg::CubeW;
  localparam int unsigned ProdW  = tbvf_pkg::ProdW;
  localparam int unsigned NumW   = tbvf_pkg::NumW;
  localparam int unsigned QuoW   = tbvf_pkg::QuoW;
  localparam int unsigned GravW  = tbvf_pkg::GravW;
  localparam int unsigned AccW   = tbvf_pkg::AccW;
  localparam int unsigned MulLat = tbvf_pkg::MulLat;
  localparam int unsigned DivLat = tbvf_pkg::DivLat;
  localparam int unsigned AddrW  = tbvf_pkg::AddrW;

  // stage numbers counted from the input register as stage 1
  localparam int unsigned StSq   = 1 + MulLat;
  localparam int unsigned StSum  = StSq + 1;
  localparam int unsigned StCube = StSum + RootW + MulLat;
  localparam int unsigned StDiv  = StCube + DivLat;
  localparam int unsigned Depth  = StDiv + 1;
  localparam int unsigned SideW  = 5 * DataW;

  localparam logic [DataW+1:0] OneQ = (DataW+2)'(1) << FracW;

  function automatic logic [MagW-1:0] mag_f(input logic [DataW+1:0] v);
    logic [DataW+1:0] n;
    n = v[DataW+1] ? (~v + 1'b1) : v;
    return n[MagW-1:0];
  endfunction

  // handshake and valid chain
  logic             en, acc;
  logic [Depth-1:0] valid_q;

  assign en            = !valid_q[Depth-1] || m_axis_tready;
  assign acc           = s_axis_tvalid && en;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], acc};
    end
  end

  // configuration register
  logic [tbvf_pkg::MuW-1:0] mu_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[AddrW-1:2] == tbvf_pkg::RegMassRatio);
  assign prdata = (paddr[AddrW-1:2] == tbvf_pkg::RegMassRatio) ? mu_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= tbvf_pkg::MuReset;
    end else if (cfg_wr) begin
      mu_q <= pwdata;
    end
  end

  // stage 1: offsets to the primaries, magnitudes and signs
  logic [DataW-1:0]   px, py, pz, vx, vy, vz;
  logic [DataW+1:0]   a1, a2, y_e, z_e;
  logic [MagW-1:0]    mag_q [4];
  logic               neg_q [4];
  logic [CoefW-1:0]   c1_q, c2_q;
  logic [SideW-1:0]   side_q;

  assign px = s_axis_tdata[0*DataW +: DataW];
  assign py = s_axis_tdata[1*DataW +: DataW];
  assign pz = s_axis_tdata[2*DataW +: DataW];
  assign vx = s_axis_tdata[3*DataW +: DataW];
  assign vy = s_axis_tdata[4*DataW +: DataW];
  assign vz = s_axis_tdata[5*DataW +: DataW];

  assign a1  = (DataW+2)'(signed'(px)) + (DataW+2)'(mu_q) - OneQ;
  assign a2  = (DataW+2)'(signed'(px)) + (DataW+2)'(mu_q);
  assign y_e = (DataW+2)'(signed'(py));
  assign z_e = (DataW+2)'(signed'(pz));

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= mag_f(a1);
      mag_q[1] <= mag_f(a2);
      mag_q[2] <= mag_f(y_e);
      mag_q[3] <= mag_f(z_e);
      neg_q[0] <= a1[DataW+1];
      neg_q[1] <= a2[DataW+1];
      neg_q[2] <= py[DataW-1];
      neg_q[3] <= pz[DataW-1];
      c1_q     <= CoefW'(mu_q);
      c2_q     <= (CoefW'(1) << FracW) - CoefW'(mu_q);
      side_q   <= {vz, vy, vx, py, px};
    end
  end

  // stages 2..3: squares and gravity numerators
  logic [SqW-1:0]   sq [4];
  logic [ProdW-1:0] prod [6];
  logic [MagW-1:0]  term_mag [6];
  logic [CoefW-1:0] term_coef [6];
  logic             term_neg [4];

  assign term_mag[0] = mag_q[0];
  assign term_mag[1] = mag_q[1];
  assign term_mag[2] = mag_q[2];
  assign term_mag[3] = mag_q[2];
  assign term_mag[4] = mag_q[3];
  assign term_mag[5] = mag_q[3];

  for (genvar i = 0; i < 4; i++) begin : g_sq
    tbvf_mul #(.AW(MagW), .BW(MagW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (mag_q[i]),
      .b_i   (mag_q[i]),
      .p_o   (sq[i])
    );
    assign term_neg[i] = neg_q[i];
  end

  for (genvar t = 0; t < 6; t++) begin : g_num
    assign term_coef[t] = (t % 2 == 0) ? c1_q : c2_q;
    tbvf_mul #(.AW(CoefW), .BW(MagW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (term_coef[t]),
      .b_i   (term_mag[t]),
      .p_o   (prod[t])
    );
  end

  // stage 4: squared distances
  logic [SumW-1:0] s_q [2];
  logic            sing;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0] <= SumW'(sq[0]) + SumW'(sq[2]) + SumW'(sq[3]);
      s_q[1] <= SumW'(sq[1]) + SumW'(sq[2]) + SumW'(sq[3]);
    end
  end

  assign sing = (s_q[0] == '0) || (s_q[1] == '0);

  // square root and cube of each distance
  logic [RootW-1:0] root [2];
  logic [SumW-1:0]  s_pass [2];
  logic [CubeW-1:0] cube [2];

  for (genvar b = 0; b < 2; b++) begin : g_body
    tbvf_sqrt #(.SW(SumW)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .s_i    (s_q[b]),
      .root_o (root[b]),
      .s_o    (s_pass[b])
    );
    tbvf_mul #(.AW(QW), .BW(RootW)) u_cube (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (s_pass[b][SumW-1:FracW]),
      .b_i   (root[b]),
      .p_o   (cube[b])
    );
  end

  // gravity quotients
  logic [ProdW-1:0]        prod_d [6];
  logic [3:0]              neg_d;
  logic signed [GravW-1:0] grav [6];
  logic [5:0]              grav_sat;

  tbvf_delay #(.W(4), .D(StCube - 1)) u_dly_neg (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({term_neg[3], term_neg[2], term_neg[1], term_neg[0]}),
    .q_o   (neg_d)
  );

  for (genvar t = 0; t < 6; t++) begin : g_term
    tbvf_delay #(.W(ProdW), .D(StCube - StSq)) u_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (prod[t]),
      .q_o   (prod_d[t])
    );
    tbvf_div #(.NW(NumW), .DW(CubeW), .QW(QuoW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({prod_d[t], FracW'(0)}),
      .den_i (cube[t % 2]),
      .neg_i (neg_d[(t < 2) ? t : (t / 2) + 1]),
      .quo_o (grav[t]),
      .sat_o (grav_sat[t])
    );
  end

  // side data to the output stage
  logic [SideW-1:0] side_d;
  logic             sing_d;

  tbvf_delay #(.W(SideW), .D(StDiv - 1)) u_dly_side (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_q),
    .q_o   (side_d)
  );

  tbvf_delay #(.W(1), .D(StDiv - StSum)) u_dly_sing (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sing),
    .q_o   (sing_d)
  );

  // output stage: sums and clipping
  logic signed [DataW-1:0] x_d, y_d, vx_d, vy_d;
  logic signed [AccW-1:0]  acc_v [3];
  logic [DataW-1:0]        acc_c [3];
  logic [2:0]              acc_sat;

  assign x_d  = signed'(side_d[0*DataW +: DataW]);
  assign y_d  = signed'(side_d[1*DataW +: DataW]);
  assign vx_d = signed'(side_d[2*DataW +: DataW]);
  assign vy_d = signed'(side_d[3*DataW +: DataW]);

  assign acc_v[0] = (AccW'(vy_d) <<< 1) + AccW'(x_d) - AccW'(grav[0]) - AccW'(grav[1]);
  assign acc_v[1] = AccW'(y_d) - (AccW'(vx_d) <<< 1) - AccW'(grav[2]) - AccW'(grav[3]);
  assign acc_v[2] = -AccW'(grav[4]) - AccW'(grav[5]);

  for (genvar j = 0; j < 3; j++) begin : g_clip
    assign acc_sat[j] = !((&acc_v[j][AccW-1:DataW-1]) || !(|acc_v[j][AccW-1:DataW-1]));
    assign acc_c[j]   = !acc_sat[j]      ? acc_v[j][DataW-1:0] :
                        acc_v[j][AccW-1] ? {1'b1, {(DataW-1){1'b0}}} :
                                           {1'b0, {(DataW-1){1'b1}}};
  end

  logic [tbvf_pkg::TDataW-1:0] tdata_q;
  logic [tbvf_pkg::TUserW-1:0] tuser_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {acc_c[2], acc_c[1], acc_c[0], side_d[SideW-1:2*DataW]};
      tuser_q <= {sing_d, (|acc_sat) || (|grav_sat)};
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

endmodule

`default_nettype wire

// ----- design/tbvf_mul.sv -----
// ----------------------------------------------------------------------------
// tbvf_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module tbvf_mul #(
  parameter int unsigned AW = 41,
  parameter int unsigned BW = 41
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire  [AW-1:0]    a_i,
  input  wire  [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    p_d, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[AL-1:0]  * b_i[BL-1:0];
      lh_q <= a_i[AL-1:0]  * b_i[BW-1:BL];
      hl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
      hh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
      p_q  <= p_d;
    end
  end

  assign p_d = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));
  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- design/tbvf_sqrt.sv -----
// ----------------------------------------------------------------------------
// tbvf_sqrt
// Pipelined integer square root, one result bit per stage; radicand rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module tbvf_sqrt #(
  parameter int unsigned SW = 84
) (
  input  wire           clk_i,
  input  wire           en_i,
  input  wire  [SW-1:0] s_i,
  output logic [SW/2-1:0] root_o,
  output logic [SW-1:0] s_o
);

  localparam int unsigned RW = SW / 2;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] s_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] s_in;
    logic [RW+3:0] cur, trial, dif;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = s_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
    end

    assign cur   = {rem_in, s_in[2*(RW-1-k)+1 -: 2]};
    assign trial = (RW+4)'({root_in, 2'b01});
    assign take  = cur >= trial;
    assign dif   = cur - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? dif[RW+1:0] : cur[RW+1:0];
        root_q[k] <= {root_in[RW-2:0], take};
        s_q[k]    <= s_in;
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign s_o    = s_q[RW-1];

endmodule

`default_nettype wire

// ----- design/tbvf_div.sv -----
// ----------------------------------------------------------------------------
// tbvf_div
// Pipelined restoring divider with a capped quotient and signed result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbvf_div #(
  parameter int unsigned NW = 106,
  parameter int unsigned DW = 94,
  parameter int unsigned QW = 51
) (
  input  wire                clk_i,
  input  wire                en_i,
  input  wire  [NW-1:0]      num_i,
  input  wire  [DW-1:0]      den_i,
  input  wire                neg_i,
  output logic signed [QW:0] quo_o,
  output logic               sat_o
);

  localparam logic [QW-1:0] Cap = {1'b1, {(QW-1){1'b0}}};

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] lo_q   [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          neg_q  [QW+1];
  logic          zero_q [QW+1];
  logic          ovf_q  [QW+1];

  logic [QW-1:0]      mag_d;
  logic               sat_d;
  logic signed [QW:0] out_q;
  logic               sat_q;

  // quotient of 2^QW or more is flagged before the first step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(num_i[NW-1:QW]);
      lo_q[0]   <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      zero_q[0] <= (num_i == '0);
      ovf_q[0]  <= (num_i[NW-1:QW] >= den_i);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] cur, dif;
    logic        take;

    assign cur  = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign take = cur >= {1'b0, den_q[k-1]};
    assign dif  = cur - {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? dif[DW-1:0] : cur[DW-1:0];
        lo_q[k]   <= lo_q[k-1] << 1;
        quo_q[k]  <= {quo_q[k-1][QW-2:0], take};
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  always_comb begin
    mag_d = quo_q[QW];
    sat_d = 1'b0;
    if (zero_q[QW]) begin
      mag_d = '0;
    end else if (ovf_q[QW] || (quo_q[QW] > Cap)) begin
      mag_d = Cap;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= neg_q[QW] ? -signed'({1'b0, mag_d}) : signed'({1'b0, mag_d});
      sat_q <= sat_d;
    end
  end

  assign quo_o = out_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// ----- design/tbvf_delay.sv -----
// ----------------------------------------------------------------------------
// tbvf_delay
// Enabled shift line that keeps side data aligned with the datapath stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tbvf_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 2
) (
  input  wire          clk_i,
  input  wire          en_i,
  input  wire  [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dly_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign q_o = dly_q[D-1];

endmodule

`default_nettype wire
